[src/fcpa_pkg.sv]
// ----------------------------------------------------------------------------
// fcpa_pkg
// Shared types and constants of the fixed-chunk pool allocator: field
// widths, operation and status codes, sequencer states and beat formats.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpa_pkg;

	localparam int ADDR_W    = 32;
	localparam int REGION_W  = 25;
	localparam int CHUNK_W   = 17;
	localparam int STATUS_W  = 3;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE   = 2'd0,
		CFG_REGION = 2'd1,
		CFG_CHUNK  = 2'd2
	} cfg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 2'd0,
		OP_FREE     = 2'd1,
		OP_FREE_ALL = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_EMPTY        = 3'd1,
		ST_OUT_OF_RANGE = 3'd2,
		ST_MISALIGNED   = 3'd3,
		ST_CHUNK_SMALL  = 3'd4,
		ST_REGION_SMALL = 3'd5,
		ST_NULL_REGION  = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC,
		S_FREE_CHK,
		S_REL_CHK,
		S_DIV,
		S_REL_SET,
		S_SWEEP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   chunk_address;
		logic [REGION_W-1:0] free_bytes;
		logic [REGION_W-1:0] used_bytes;
		logic                all_free;
	} rsp_t;

endpackage

`default_nettype wire

[src/fcpa_div.sv]
// ----------------------------------------------------------------------------
// fcpa_div
// Restoring divider, one quotient bit per cycle, for quotients known to fit
// in IDX_W bits. Used for chunk index lookup and for the chunk count.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpa_div #(
	parameter int IDX_W = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fcpa_pkg::ADDR_W-1:0]   dividend,
	input  logic [fcpa_pkg::CHUNK_W-1:0]  divisor,
	output logic                          done,
	output logic [IDX_W-1:0]              quotient,
	output logic [fcpa_pkg::ADDR_W-1:0]   remainder
);

	localparam int BIT_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;
	localparam int DVS_W = fcpa_pkg::CHUNK_W + IDX_W;
	localparam int CMP_W = (DVS_W > fcpa_pkg::ADDR_W) ? DVS_W : fcpa_pkg::ADDR_W;

	logic                          busy_q;
	logic                          done_q;
	logic [BIT_W-1:0]              bit_q;
	logic [fcpa_pkg::ADDR_W-1:0]   rem_q;
	logic [fcpa_pkg::CHUNK_W-1:0]  dvs_q;
	logic [IDX_W-1:0]              quo_q;
	logic [CMP_W-1:0]              trial;
	logic [CMP_W-1:0]              rem_ext;
	logic                          fits;

	assign trial   = CMP_W'(dvs_q) << bit_q;
	assign rem_ext = CMP_W'(rem_q);
	assign fits    = rem_ext >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
			bit_q <= BIT_W'(IDX_W - 1);
		end else if (busy_q) begin
			if (fits) begin
				rem_q        <= fcpa_pkg::ADDR_W'(rem_ext - trial);
				quo_q[bit_q] <= 1'b1;
			end
			if (bit_q != '0) begin
				bit_q <= bit_q - BIT_W'(1);
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[src/fifo_fixed_chunk_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// fifo_fixed_chunk_pool_allocator_core
// Fixed-chunk pool allocator with a FIFO free list kept in a link memory.
//
// Requests arrive on req (valid/stall), one result beat leaves on rsp for
// every request. Configuration is written through cfg_we/cfg_index/cfg_data
// and takes effect at the next free-all.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken, in the cycle after the load.
// From accept to the result register: a query goes straight to the result
// stage; an alloc reads the link memory; a free checks the offset, then the
// divider finds the chunk index, one divider bit per cycle; a free-all runs
// the chunk count division (skipped when the chunk count saturates), then
// the relink sweep writes one link memory entry per cycle. An out-of-bounds
// free or a free-all that fails its checks goes straight to the result.
// When rsp is stalled the result holds and the block takes at most one
// more request, which then waits for the output register.
// After reset the pool is empty and holds no chunks (base address zero),
// the configuration registers hold their defaults and no sweep runs.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_fixed_chunk_pool_allocator_core #(
	parameter int MAX_CHUNKS = 1024,
	parameter int MIN_CHUNK  = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fcpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fcpa_pkg::ADDR_W-1:0]      cfg_data,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  fcpa_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output fcpa_pkg::rsp_t                   rsp
);

	localparam int ADDR_W   = fcpa_pkg::ADDR_W;
	localparam int REGION_W = fcpa_pkg::REGION_W;
	localparam int CHUNK_W  = fcpa_pkg::CHUNK_W;
	localparam int IDX_W    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CNT_W    = $clog2(MAX_CHUNKS + 1);
	localparam int PROD_W   = IDX_W + CHUNK_W;
	localparam int USE_W    = CNT_W + CHUNK_W;
	localparam int SAT_W    = (CNT_W + CHUNK_W > REGION_W) ? CNT_W + CHUNK_W : REGION_W;

	localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(MAX_CHUNKS - 1);
	localparam logic [CNT_W-1:0]   MAX_CNT  = CNT_W'(MAX_CHUNKS);
	localparam logic [SAT_W-1:0]   MAX_SAT  = SAT_W'(MAX_CHUNKS);
	localparam logic [CHUNK_W-1:0] MIN_SZ   = CHUNK_W'(MIN_CHUNK);

	fcpa_pkg::state_t state_q, state_d;

	// configuration
	logic [ADDR_W-1:0]   base_cfg_q;
	logic [REGION_W-1:0] region_cfg_q;
	logic [CHUNK_W-1:0]  chunk_cfg_q;

	// pool state
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    tail_q;
	logic                empty_q;
	logic [CNT_W-1:0]    fcnt_q;
	logic [CNT_W-1:0]    ccnt_q;
	logic [ADDR_W-1:0]   live_base_q;
	logic [CHUNK_W-1:0]  live_chunk_q;
	logic [REGION_W-1:0] usable_q;
	logic [REGION_W-1:0] fbytes_q;

	// per-request work registers
	logic [ADDR_W-1:0]            off_q;
	logic [PROD_W-1:0]            prod_s1;
	logic [fcpa_pkg::STATUS_W-1:0] stat_q;
	logic [ADDR_W-1:0]            got_q;
	logic [CNT_W-1:0]             n_q;
	logic [IDX_W-1:0]             sweep_q;
	logic                         div_rel_q;

	// link memory
	logic [IDX_W-1:0] link_mem [MAX_CHUNKS];
	logic [IDX_W-1:0] rd_s1;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [IDX_W-1:0] mem_wd;

	// divider
	logic                div_start;
	logic [ADDR_W-1:0]   div_dividend;
	logic [CHUNK_W-1:0]  div_divisor;
	logic                div_done;
	logic [IDX_W-1:0]    div_quo;
	logic [ADDR_W-1:0]   div_rem;

	// output register
	logic           rsp_valid_q;
	fcpa_pkg::rsp_t rsp_q;
	logic           rsp_load;

	logic accept;
	logic off_oob;
	logic rel_fail;
	logic rel_sat;
	logic free_ok;
	logic sweep_last;

	assign accept     = req_valid && !req_stall;
	assign off_oob    = off_q >= ADDR_W'(usable_q);
	assign rel_fail   = (base_cfg_q == '0) || (chunk_cfg_q < MIN_SZ)
		|| (region_cfg_q < REGION_W'(chunk_cfg_q));
	assign rel_sat    = SAT_W'(region_cfg_q) >= MAX_SAT * SAT_W'(chunk_cfg_q);
	assign free_ok    = div_rem == '0;
	assign sweep_last = sweep_q == LAST_IDX;

	fcpa_div #(
		.IDX_W (IDX_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcpa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_stall    = 1'b1;
		div_start    = 1'b0;
		div_dividend = off_q;
		div_divisor  = live_chunk_q;
		mem_we       = 1'b0;
		mem_wa       = tail_q;
		mem_wd       = div_quo;
		rsp_load     = 1'b0;
		case (state_q)
			fcpa_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					case (req.operation)
						fcpa_pkg::OP_ALLOC:    state_d = fcpa_pkg::S_ALLOC;
						fcpa_pkg::OP_FREE:     state_d = fcpa_pkg::S_FREE_CHK;
						fcpa_pkg::OP_FREE_ALL: state_d = fcpa_pkg::S_REL_CHK;
						fcpa_pkg::OP_QUERY:    state_d = fcpa_pkg::S_RESP;
						default:               state_d = fcpa_pkg::S_IDLE;
					endcase
				end
			end
			fcpa_pkg::S_ALLOC: begin
				state_d = fcpa_pkg::S_RESP;
			end
			fcpa_pkg::S_FREE_CHK: begin
				if (off_oob) begin
					state_d = fcpa_pkg::S_RESP;
				end else begin
					div_start = 1'b1;
					state_d   = fcpa_pkg::S_DIV;
				end
			end
			fcpa_pkg::S_REL_CHK: begin
				if (rel_fail) begin
					state_d = fcpa_pkg::S_RESP;
				end else if (rel_sat) begin
					state_d = fcpa_pkg::S_REL_SET;
				end else begin
					div_start    = 1'b1;
					div_dividend = ADDR_W'(region_cfg_q);
					div_divisor  = chunk_cfg_q;
					state_d      = fcpa_pkg::S_DIV;
				end
			end
			fcpa_pkg::S_DIV: begin
				if (div_done) begin
					if (div_rel_q) begin
						state_d = fcpa_pkg::S_REL_SET;
					end else begin
						mem_we  = free_ok && !empty_q;
						state_d = fcpa_pkg::S_RESP;
					end
				end
			end
			fcpa_pkg::S_REL_SET: begin
				state_d = fcpa_pkg::S_SWEEP;
			end
			fcpa_pkg::S_SWEEP: begin
				mem_we = 1'b1;
				mem_wa = sweep_q;
				mem_wd = sweep_last ? '0 : sweep_q + IDX_W'(1);
				if (sweep_last) begin
					state_d = fcpa_pkg::S_RESP;
				end
			end
			fcpa_pkg::S_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = fcpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fcpa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		rd_s1 <= link_mem[head_q];
	end

	// configuration and pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_cfg_q   <= '0;
			region_cfg_q <= REGION_W'(65536);
			chunk_cfg_q  <= CHUNK_W'(64);
			head_q       <= '0;
			tail_q       <= '0;
			empty_q      <= 1'b1;
			fcnt_q       <= '0;
			ccnt_q       <= '0;
			live_base_q  <= '0;
			live_chunk_q <= '0;
			usable_q     <= '0;
			fbytes_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fcpa_pkg::CFG_BASE:   base_cfg_q   <= cfg_data;
					fcpa_pkg::CFG_REGION: region_cfg_q <= REGION_W'(cfg_data);
					fcpa_pkg::CFG_CHUNK:  chunk_cfg_q  <= CHUNK_W'(cfg_data);
					default: ;
				endcase
			end
			case (state_q)
				fcpa_pkg::S_ALLOC: begin
					if (!empty_q) begin
						if (head_q == tail_q) begin
							empty_q  <= 1'b1;
							fcnt_q   <= '0;
							fbytes_q <= '0;
						end else begin
							head_q <= rd_s1;
							if (fcnt_q > CNT_W'(1)) begin
								fcnt_q   <= fcnt_q - CNT_W'(1);
								fbytes_q <= fbytes_q - REGION_W'(live_chunk_q);
							end
						end
					end
				end
				fcpa_pkg::S_REL_CHK: begin
					if (rel_fail) begin
						head_q       <= '0;
						tail_q       <= '0;
						empty_q      <= 1'b1;
						fcnt_q       <= '0;
						ccnt_q       <= '0;
						live_base_q  <= '0;
						live_chunk_q <= '0;
						usable_q     <= '0;
						fbytes_q     <= '0;
					end
				end
				fcpa_pkg::S_DIV: begin
					if (div_done && !div_rel_q && free_ok) begin
						if (empty_q) begin
							head_q   <= div_quo;
							empty_q  <= 1'b0;
							fcnt_q   <= CNT_W'(1);
							fbytes_q <= REGION_W'(live_chunk_q);
						end else if (fcnt_q < ccnt_q) begin
							fcnt_q   <= fcnt_q + CNT_W'(1);
							fbytes_q <= fbytes_q + REGION_W'(live_chunk_q);
						end
						tail_q <= div_quo;
					end
				end
				fcpa_pkg::S_REL_SET: begin
					head_q       <= '0;
					tail_q       <= IDX_W'(n_q - CNT_W'(1));
					empty_q      <= 1'b0;
					fcnt_q       <= n_q;
					ccnt_q       <= n_q;
					live_base_q  <= base_cfg_q;
					live_chunk_q <= chunk_cfg_q;
					usable_q     <= REGION_W'(USE_W'(n_q) * USE_W'(chunk_cfg_q));
					fbytes_q     <= REGION_W'(USE_W'(n_q) * USE_W'(chunk_cfg_q));
				end
				default: ;
			endcase
		end
	end

	// per-request work registers
	always_ff @(posedge clk) begin
		case (state_q)
			fcpa_pkg::S_IDLE: begin
				if (accept) begin
					stat_q  <= fcpa_pkg::ST_OK;
					got_q   <= '0;
					off_q   <= req.address - live_base_q;
					prod_s1 <= PROD_W'(head_q) * PROD_W'(live_chunk_q);
				end
			end
			fcpa_pkg::S_ALLOC: begin
				if (empty_q) begin
					stat_q <= fcpa_pkg::ST_EMPTY;
				end else begin
					got_q <= live_base_q + ADDR_W'(prod_s1);
				end
			end
			fcpa_pkg::S_FREE_CHK: begin
				div_rel_q <= 1'b0;
				if (off_oob) begin
					stat_q <= fcpa_pkg::ST_OUT_OF_RANGE;
				end
			end
			fcpa_pkg::S_REL_CHK: begin
				div_rel_q <= 1'b1;
				n_q       <= MAX_CNT;
				if (base_cfg_q == '0) begin
					stat_q <= fcpa_pkg::ST_NULL_REGION;
				end else if (chunk_cfg_q < MIN_SZ) begin
					stat_q <= fcpa_pkg::ST_CHUNK_SMALL;
				end else if (region_cfg_q < REGION_W'(chunk_cfg_q)) begin
					stat_q <= fcpa_pkg::ST_REGION_SMALL;
				end
			end
			fcpa_pkg::S_DIV: begin
				if (div_done) begin
					if (div_rel_q) begin
						n_q <= CNT_W'(div_quo);
					end else if (!free_ok) begin
						stat_q <= fcpa_pkg::ST_MISALIGNED;
					end
				end
			end
			fcpa_pkg::S_REL_SET: begin
				sweep_q <= '0;
			end
			fcpa_pkg::S_SWEEP: begin
				sweep_q <= sweep_q + IDX_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status        <= stat_q;
			rsp_q.chunk_address <= got_q;
			rsp_q.free_bytes    <= fbytes_q;
			rsp_q.used_bytes    <= usable_q - fbytes_q;
			rsp_q.all_free      <= fcnt_q >= ccnt_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[src/fcpa_chk.sv]
// ----------------------------------------------------------------------------
// fcpa_chk
// Port-level checks of the pool allocator core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpa_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input fcpa_pkg::rsp_t rsp
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// one request at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in work");

	a_addr_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != fcpa_pkg::ST_OK |-> rsp.chunk_address == '0)
		else $error("chunk address on a failed request");

	a_all_free_used: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.all_free |-> rsp.used_bytes == '0)
		else $error("used bytes while every chunk is free");

	a_empty_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == fcpa_pkg::ST_EMPTY |-> rsp.free_bytes == '0)
		else $error("free bytes reported with an empty list");

endmodule

bind fifo_fixed_chunk_pool_allocator_core fcpa_chk u_fcpa_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
